>>> design/trajectory_tracking_control_law_macros.svh
// Assertion macros for the trajectory tracking control law.
`ifndef TRAJECTORY_TRACKING_CONTROL_LAW_MACROS_SVH
`define TRAJECTORY_TRACKING_CONTROL_LAW_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TTCL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define TTCL_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTCL_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define TTCL_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> design/ttcl_pkg.sv
// Shared types, constants and the exp ROM entry function.
`timescale 1ns / 1ps
`default_nettype none
package ttcl_pkg;

    localparam int CFG_W = 15;
    localparam int CFG_IDX_W = 3;
    localparam int DATA_W = 16;
    localparam int HEAD_W = 15;
    localparam int EXP_W = 13;
    localparam int NUM_STAGES = 5;
    localparam int EXP_TABLE_ENTRIES_DEF = 256;
    localparam logic [CFG_W-1:0] REG_RESET = 15'd4096;
    // 0.05 m in Q12 is 204.8: reached when err_x <= 204
    localparam logic signed [DATA_W-1:0] GOAL_X_LIMIT = 16'sd205;
    localparam longint Q24_ONE = 64'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_X        = 3'd0,
        CFG_GAIN_Y        = 3'd1,
        CFG_GAIN_HEADING  = 3'd2,
        CFG_MAX_ROTATION  = 3'd3,
        CFG_MAX_SPEED     = 3'd4,
        CFG_MAX_LAT_ERR   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] gain_x;
        logic [CFG_W-1:0] gain_y;
        logic [CFG_W-1:0] gain_heading;
        logic [CFG_W-1:0] max_rotation;
        logic [CFG_W-1:0] max_speed;
        logic [CFG_W-1:0] max_lateral_error;
    } cfg_t;

    // exp(-x^2) in Q12 for x in Q12: 4th-order Taylor of exp(-x^2/256),
    // then squared eight times, rounded half up.
    function automatic logic [EXP_W-1:0] exp_q12(input longint x);
        longint t;
        longint u;
        longint u2;
        longint u3;
        longint u4;
        longint p;
        t  = x * x;
        u  = t >>> 8;
        u2 = (u * u) >>> 24;
        u3 = (u2 * u) >>> 24;
        u4 = (u3 * u) >>> 24;
        p  = Q24_ONE - u + u2 / 2 - u3 / 6 + u4 / 24;
        for (int k = 0; k < 8; k++) begin
            p = (p * p) >>> 24;
        end
        return EXP_W'((p + 64'd2048) >>> 12);
    endfunction

endpackage
`default_nettype wire

>>> design/ttcl_cfg_regs.sv
// Configuration register file.
`timescale 1ns / 1ps
`default_nettype none
module ttcl_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ttcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ttcl_pkg::CFG_W-1:0]    cfg_wdata,
    output ttcl_pkg::cfg_t                     cfg
);

    ttcl_pkg::cfg_t cfg_reg;
    ttcl_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (ttcl_pkg::cfg_index_t'(cfg_index))
                ttcl_pkg::CFG_GAIN_X:       cfg_next.gain_x = cfg_wdata;
                ttcl_pkg::CFG_GAIN_Y:       cfg_next.gain_y = cfg_wdata;
                ttcl_pkg::CFG_GAIN_HEADING: cfg_next.gain_heading = cfg_wdata;
                ttcl_pkg::CFG_MAX_ROTATION: cfg_next.max_rotation = cfg_wdata;
                ttcl_pkg::CFG_MAX_SPEED:    cfg_next.max_speed = cfg_wdata;
                ttcl_pkg::CFG_MAX_LAT_ERR:  cfg_next.max_lateral_error = cfg_wdata;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{
                gain_x:            ttcl_pkg::REG_RESET,
                gain_y:            ttcl_pkg::REG_RESET,
                gain_heading:      ttcl_pkg::REG_RESET,
                max_rotation:      ttcl_pkg::REG_RESET,
                max_speed:         ttcl_pkg::REG_RESET,
                max_lateral_error: ttcl_pkg::REG_RESET
            };
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> design/ttcl_exp_rom.sv
// exp(-theta^2) lookup ROM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ttcl_exp_rom #(
    parameter int ENTRIES = ttcl_pkg::EXP_TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(ENTRIES)
) (
    input  wire logic                         aclk,
    input  wire logic                         rd_en,
    input  wire logic [IDX_W-1:0]             rd_idx,
    output logic      [ttcl_pkg::EXP_W-1:0]   rd_data
);

    logic [ttcl_pkg::EXP_W-1:0] rom_w [ENTRIES];
    logic [ttcl_pkg::EXP_W-1:0] rd_data_reg;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_rom
        localparam longint X_Q12 = (longint'(i) * 16384) / ENTRIES;
        assign rom_w[i] = ttcl_pkg::exp_q12(X_Q12);
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom_w[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> design/ttcl_datapath.sv
// Five-stage datapath of the control law; each stage loads on its enable.
`timescale 1ns / 1ps
`default_nettype none
module ttcl_datapath #(
    parameter int EXP_TABLE_ENTRIES = ttcl_pkg::EXP_TABLE_ENTRIES_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic [ttcl_pkg::NUM_STAGES-1:0]       stage_en,
    input  wire ttcl_pkg::cfg_t                        cfg,
    input  wire logic signed [ttcl_pkg::DATA_W-1:0]    err_x,
    input  wire logic signed [ttcl_pkg::DATA_W-1:0]    err_y,
    input  wire logic signed [ttcl_pkg::HEAD_W-1:0]    err_heading,
    input  wire logic signed [ttcl_pkg::DATA_W-1:0]    ref_linear,
    input  wire logic signed [ttcl_pkg::DATA_W-1:0]    ref_angular,
    input  wire logic                                  is_final,
    output logic signed [ttcl_pkg::DATA_W-1:0]         cmd_linear,
    output logic signed [ttcl_pkg::DATA_W-1:0]         cmd_angular,
    output logic                                       at_goal
);

    localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
    localparam int PW = ttcl_pkg::HEAD_W + IDX_W + 1;
    localparam int RW = PW - 14;

    // stage 1: products, lateral clamp, ROM index
    logic signed [15:0] gx_s, gy_s, gh_s, lat_lim;
    logic signed [15:0] eth16, ey_cl;
    logic [14:0]        mag;
    logic [PW-1:0]      idx_prod;
    logic [RW-1:0]      idx_raw;
    logic [IDX_W-1:0]   idx_c;

    logic signed [31:0] s1_pgx_reg, s1_pgy_reg;
    logic signed [30:0] s1_pgh_reg;
    logic signed [15:0] s1_rv_reg, s1_rw_reg, s1_ey_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_goal_reg;

    always_comb begin
        gx_s    = $signed({1'b0, cfg.gain_x});
        gy_s    = $signed({1'b0, cfg.gain_y});
        gh_s    = $signed({1'b0, cfg.gain_heading});
        lat_lim = $signed({1'b0, cfg.max_lateral_error});
        eth16   = 16'(err_heading);
        mag     = 15'(eth16 < 0 ? -eth16 : eth16);
        idx_prod = PW'(mag) * PW'(EXP_TABLE_ENTRIES);
        idx_raw  = idx_prod[PW-1:14];
        if (idx_raw > RW'(EXP_TABLE_ENTRIES - 1)) begin
            idx_c = IDX_W'(EXP_TABLE_ENTRIES - 1);
        end else begin
            idx_c = idx_raw[IDX_W-1:0];
        end
        priority if (err_y < -lat_lim) begin
            ey_cl = -lat_lim;
        end else if (err_y > lat_lim) begin
            ey_cl = lat_lim;
        end else begin
            ey_cl = err_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s1_pgx_reg  <= 32'(gx_s) * 32'(err_x);
            s1_pgy_reg  <= 32'(gy_s) * 32'(ref_linear);
            s1_pgh_reg  <= 31'(gh_s) * 31'(err_heading);
            s1_rv_reg   <= ref_linear;
            s1_rw_reg   <= ref_angular;
            s1_ey_reg   <= ey_cl;
            s1_idx_reg  <= idx_c;
            s1_goal_reg <= is_final && (err_x < ttcl_pkg::GOAL_X_LIMIT);
        end
    end

    // stage 2: ROM read, floored first-order sums
    logic [ttcl_pkg::EXP_W-1:0] s2_e;
    logic signed [19:0] s2_lin_reg, s2_ang_reg;
    logic signed [31:0] s2_pgy_reg;
    logic signed [15:0] s2_ey_reg;
    logic               s2_goal_reg;

    ttcl_exp_rom #(
        .ENTRIES (EXP_TABLE_ENTRIES)
    ) u_exp_rom (
        .aclk    (aclk),
        .rd_en   (stage_en[1]),
        .rd_idx  (s1_idx_reg),
        .rd_data (s2_e)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s2_lin_reg  <= 20'(s1_rv_reg) + s1_pgx_reg[31:12];
            s2_ang_reg  <= 20'(s1_rw_reg) + 20'($signed(s1_pgh_reg[30:12]));
            s2_pgy_reg  <= s1_pgy_reg;
            s2_ey_reg   <= s1_ey_reg;
            s2_goal_reg <= s1_goal_reg;
        end
    end

    // stage 3: e*ey, linear saturation and speed cap
    logic signed [19:0] speed_cap;
    logic signed [15:0] lin_c;
    logic signed [29:0] s3_pey_reg;
    logic signed [31:0] s3_pgy_reg;
    logic signed [19:0] s3_ang_reg;
    logic signed [15:0] s3_lin_reg;
    logic               s3_goal_reg;

    always_comb begin
        speed_cap = 20'($signed({1'b0, cfg.max_speed}));
        priority if (s2_lin_reg < -20'sd32768) begin
            lin_c = -16'sd32768;
        end else if (s2_lin_reg > speed_cap) begin
            lin_c = speed_cap[15:0];
        end else if (s2_lin_reg > 20'sd32767) begin
            lin_c = 16'sd32767;
        end else begin
            lin_c = s2_lin_reg[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s3_pey_reg  <= 30'($signed({1'b0, s2_e})) * 30'(s2_ey_reg);
            s3_pgy_reg  <= s2_pgy_reg;
            s3_ang_reg  <= s2_ang_reg;
            s3_lin_reg  <= lin_c;
            s3_goal_reg <= s2_goal_reg;
        end
    end

    // stage 4: lateral term, floored by 36 bits
    logic signed [61:0] lat_prod;
    logic signed [25:0] s4_lat_reg;
    logic signed [19:0] s4_ang_reg;
    logic signed [15:0] s4_lin_reg;
    logic               s4_goal_reg;

    assign lat_prod = s3_pgy_reg * s3_pey_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s4_lat_reg  <= lat_prod[61:36];
            s4_ang_reg  <= s3_ang_reg;
            s4_lin_reg  <= s3_lin_reg;
            s4_goal_reg <= s3_goal_reg;
        end
    end

    // stage 5: angular sum, rotation clamp, goal override
    logic signed [26:0] ang_sum, rot_lim;
    logic signed [15:0] ang_c;
    logic signed [15:0] out_lin_reg, out_ang_reg;
    logic               out_goal_reg;

    always_comb begin
        rot_lim = 27'($signed({1'b0, cfg.max_rotation}));
        ang_sum = 27'(s4_ang_reg) + 27'(s4_lat_reg);
        priority if (ang_sum < -rot_lim) begin
            ang_c = 16'(-rot_lim);
        end else if (ang_sum > rot_lim) begin
            ang_c = rot_lim[15:0];
        end else begin
            ang_c = ang_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            out_lin_reg  <= s4_goal_reg ? 16'sd0 : s4_lin_reg;
            out_ang_reg  <= s4_goal_reg ? 16'sd0 : ang_c;
            out_goal_reg <= s4_goal_reg;
        end
    end

    assign cmd_linear  = out_lin_reg;
    assign cmd_angular = out_ang_reg;
    assign at_goal     = out_goal_reg;

endmodule
`default_nettype wire

>>> design/trajectory_tracking_control_law.sv
// Top level of the trajectory tracking control law: handshake, stages, config.
//
// Usage:
//  - Input channel s_*: one request carries err_x, err_y, err_heading,
//    ref_linear, ref_angular and is_final, taken when s_valid && s_ready.
//  - Result channel m_*: one result per request, in order, holding
//    cmd_linear, cmd_angular and at_goal, taken when m_valid && m_ready.
//  - Config port: cfg_wr_en writes cfg_wdata into register cfg_index
//    (0 gain_x, 1 gain_y, 2 gain_heading, 3 max_rotation, 4 max_speed,
//    5 max_lateral_error); other indexes are dropped. Write only while idle.
//  - m_valid rises once a request has passed the five-stage pipeline
//    (multiplier, ROM read, e*ey multiplier, 32x30 lateral multiplier,
//    clamp and output register). Throughput: one request per cycle
//    unless a low m_ready stalls the output.
//  - Each stage holds a valid bit; a stage loads when it is empty or the
//    stage after it moves, so bubbles close up under a stall and s_ready
//    only drops once every stage is full and m_ready is low.
//  - Reset (aresetn low, synchronous) empties the pipeline and sets all
//    config registers to 1.0 (4096 in Q12).
`timescale 1ns / 1ps
`default_nettype none
`include "trajectory_tracking_control_law_macros.svh"
module trajectory_tracking_control_law #(
    parameter int EXP_TABLE_ENTRIES = ttcl_pkg::EXP_TABLE_ENTRIES_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration writes
    input  wire logic                                  cfg_wr_en,
    input  wire logic [ttcl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ttcl_pkg::CFG_W-1:0]            cfg_wdata,
    // input requests
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [ttcl_pkg::DATA_W-1:0]    s_err_x,
    input  wire logic signed [ttcl_pkg::DATA_W-1:0]    s_err_y,
    input  wire logic signed [ttcl_pkg::HEAD_W-1:0]    s_err_heading,
    input  wire logic signed [ttcl_pkg::DATA_W-1:0]    s_ref_linear,
    input  wire logic signed [ttcl_pkg::DATA_W-1:0]    s_ref_angular,
    input  wire logic                                  s_is_final,
    // results
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [ttcl_pkg::DATA_W-1:0]         m_cmd_linear,
    output logic signed [ttcl_pkg::DATA_W-1:0]         m_cmd_angular,
    output logic                                       m_at_goal
);

    localparam int NS = ttcl_pkg::NUM_STAGES;

    ttcl_pkg::cfg_t cfg;
    logic [NS-1:0]  valid_reg, valid_next;
    logic [NS-1:0]  stage_en;

    ttcl_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Stage k may load when it is empty or its content moves on.
    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    ttcl_datapath #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_datapath (
        .aclk         (aclk),
        .stage_en     (stage_en),
        .cfg          (cfg),
        .err_x        (s_err_x),
        .err_y        (s_err_y),
        .err_heading  (s_err_heading),
        .ref_linear   (s_ref_linear),
        .ref_angular  (s_ref_angular),
        .is_final     (s_is_final),
        .cmd_linear   (m_cmd_linear),
        .cmd_angular  (m_cmd_angular),
        .at_goal      (m_at_goal)
    );

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NS-1];

    // goal override zeroes both commands
    `TTCL_ASSERT_IMP(a_goal_zero, aclk, aresetn, m_valid && m_at_goal, (m_cmd_linear == 16'sd0) && (m_cmd_angular == 16'sd0), "goal result with nonzero command")
    // linear command never exceeds the speed cap
    `TTCL_ASSERT_IMP(a_speed_cap, aclk, aresetn, m_valid && !m_at_goal, m_cmd_linear <= $signed(16'(cfg.max_speed)), "linear command above max_speed")
    // angular command within the rotation limit
    `TTCL_ASSERT_IMP(a_rot_lim, aclk, aresetn, m_valid && !m_at_goal, (m_cmd_angular <= $signed(16'(cfg.max_rotation))) && (m_cmd_angular >= -$signed(16'(cfg.max_rotation))), "angular command outside max_rotation")
    // a full pipeline with a stalled receiver takes no new request
    `TTCL_ASSERT_IMP(a_full_stall, aclk, aresetn, (&valid_reg) && !m_ready, !s_ready, "request taken while pipeline full")
    // the last stage moves into an empty output register
    `TTCL_ASSERT_NXT(a_drain, aclk, aresetn, valid_reg[NS-2] && !valid_reg[NS-1], m_valid, "last stage did not reach the output")

endmodule
`default_nettype wire
